[rtl/core/fyse_pkg.sv]
package fyse_pkg;

  // word field widths
  localparam int unsigned OpW     = 2;
  localparam int unsigned ValueW  = 16;
  localparam int unsigned IndexW  = 8;
  localparam int unsigned RndW    = 32;
  localparam int unsigned RdValW  = 16;
  localparam int unsigned PosW    = 8;
  localparam int unsigned StatusW = 2;

  // packed port widths, data widths padded to whole bytes
  localparam int unsigned InDataW  = 56;
  localparam int unsigned InUserW  = OpW;
  localparam int unsigned OutDataW = 32;

  // random word reduction runs one bit per cycle
  localparam int unsigned RndCntW = $clog2(RndW);

  typedef enum logic [OpW-1:0] {
    OP_LOAD  = 2'd0,
    OP_STEP  = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_DIV  = 8'b0000_0010,
    ST_RDA  = 8'b0000_0100,
    ST_RDB  = 8'b0000_1000,
    ST_WRA  = 8'b0001_0000,
    ST_WRB  = 8'b0010_0000,
    ST_RDX  = 8'b0100_0000,
    ST_RES  = 8'b1000_0000
  } state_e;

endpackage

[rtl/core/fisher_yates_shuffle_engine_unit.sv]
// Forward Fisher-Yates shuffle engine over an on-chip store of element words.
// Input channel (s_axis): tuser carries the operation (load, step, read, clear),
// tdata carries value, read index and a 32-bit random word. Output channel
// (m_axis): one result word per input word, holding the read value, the cursor
// after the operation, the done flag and a status code.
// One word is worked on at a time; tready is high only while the engine is idle.
// Steps from accept until the result sits in the output register:
//   load, clear, rejected operations: straight to the result state
//   read: a synchronous store read, then the result state
//   shuffle step: bit-serial random mod span, then read, read,
//   write, write on the store, then the result state
// The engine returns to idle for the next word as the result is registered.
// If the receiver stalls, the result stays in the output register and the
// engine still takes the next word; it only waits before publishing that
// word's result until the register is taken.
// Reset clears the element count, the cursor and the output valid at once;
// the store itself is not cleared and needs no pass, since only positions
// below the count are ever read.
module fisher_yates_shuffle_engine_unit #(
  parameter int unsigned STORE_DEPTH  = 256,
  parameter int unsigned ELEMENT_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // value [15:0], index [23:16], random_word [55:24]
  input  logic [fyse_pkg::InDataW-1:0]  s_axis_tdata_i,
  // op [1:0]
  input  logic [fyse_pkg::InUserW-1:0]  s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // read_value [15:0], step_position [23:16], shuffle_done [24], status [26:25]
  output logic [fyse_pkg::OutDataW-1:0] m_axis_tdata_o
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned IW = (CW > fyse_pkg::IndexW) ? CW : fyse_pkg::IndexW;
  localparam int unsigned EW = ELEMENT_BITS;

  fyse_pkg::state_e  state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [AW-1:0]     cursor_q, cursor_d;
  logic [CW-1:0]     span_q, span_d;
  logic [CW-1:0]     rem_q, rem_d;
  logic [fyse_pkg::RndW-1:0]    dvd_q, dvd_d;
  logic [fyse_pkg::RndCntW-1:0] bit_q, bit_d;
  logic [EW-1:0]     tmp_q, tmp_d;
  logic [fyse_pkg::RdValW-1:0]  res_val_q, res_val_d;
  fyse_pkg::status_e res_st_q, res_st_d;
  logic              m_valid_q, m_valid_d;
  logic [fyse_pkg::OutDataW-1:0] m_data_q, m_data_d;

  // element store, one write and one registered read per cycle
  logic [EW-1:0]     mem_q [STORE_DEPTH];
  logic [EW-1:0]     mem_rd_q;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [EW-1:0]     mem_wdata;

  logic                          in_fire;
  fyse_pkg::op_e                 in_op;
  logic [fyse_pkg::ValueW-1:0]   in_value;
  logic [fyse_pkg::IndexW-1:0]   in_index;
  logic [fyse_pkg::RndW-1:0]     in_rnd;
  logic [IW-1:0]                 idx_ext;
  logic                          no_step;
  logic [CW:0]                   trial;
  logic                          trial_ok;
  logic [AW-1:0]                 partner;

  assign s_axis_tready_o = (state_q == fyse_pkg::ST_IDLE);
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign in_op    = fyse_pkg::op_e'(s_axis_tuser_i);
  assign in_value = s_axis_tdata_i[15:0];
  assign in_index = s_axis_tdata_i[23:16];
  assign in_rnd   = s_axis_tdata_i[55:24];
  assign idx_ext  = IW'(in_index);

  // also the done flag: no swap left for the current count
  assign no_step = ((CW+1)'(cursor_q) + (CW+1)'(1)) >= (CW+1)'(count_q);

  // restoring remainder step
  assign trial    = {rem_q, dvd_q[fyse_pkg::RndW-1]};
  assign trial_ok = trial >= {1'b0, span_q};
  assign partner  = cursor_q + rem_q[AW-1:0];

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    cursor_d  = cursor_q;
    span_d    = span_q;
    rem_d     = rem_q;
    dvd_d     = dvd_q;
    bit_d     = bit_q;
    tmp_d     = tmp_q;
    res_val_d = res_val_q;
    res_st_d  = res_st_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_data_d  = m_data_q;
    mem_we    = 1'b0;
    mem_waddr = cursor_q;
    mem_wdata = mem_rd_q;
    mem_re    = 1'b0;
    mem_raddr = cursor_q;

    case (state_q)
      fyse_pkg::ST_IDLE: begin
        if (in_fire) begin
          res_val_d = '0;
          res_st_d  = fyse_pkg::STAT_OK;
          state_d   = fyse_pkg::ST_RES;
          case (in_op)
            fyse_pkg::OP_LOAD: begin
              if (count_q == CW'(STORE_DEPTH)) begin
                res_st_d = fyse_pkg::STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_q[AW-1:0];
                mem_wdata = EW'(in_value);
                count_d   = count_q + CW'(1);
              end
            end
            fyse_pkg::OP_STEP: begin
              if (no_step) begin
                res_st_d = fyse_pkg::STAT_EMPTY;
              end else begin
                span_d  = count_q - CW'(cursor_q);
                rem_d   = '0;
                dvd_d   = in_rnd;
                bit_d   = '1;
                state_d = fyse_pkg::ST_DIV;
              end
            end
            fyse_pkg::OP_READ: begin
              if (idx_ext >= IW'(count_q)) begin
                res_st_d = fyse_pkg::STAT_RANGE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = idx_ext[AW-1:0];
                state_d   = fyse_pkg::ST_RDX;
              end
            end
            fyse_pkg::OP_CLEAR: begin
              count_d  = '0;
              cursor_d = '0;
            end
            default: begin
              state_d = fyse_pkg::ST_RES;
            end
          endcase
        end
      end
      fyse_pkg::ST_DIV: begin
        rem_d = trial_ok ? CW'(trial - {1'b0, span_q}) : trial[CW-1:0];
        dvd_d = {dvd_q[fyse_pkg::RndW-2:0], 1'b0};
        bit_d = bit_q - fyse_pkg::RndCntW'(1);
        if (bit_q == '0) begin
          state_d = fyse_pkg::ST_RDA;
        end
      end
      fyse_pkg::ST_RDA: begin
        mem_re    = 1'b1;
        mem_raddr = cursor_q;
        state_d   = fyse_pkg::ST_RDB;
      end
      fyse_pkg::ST_RDB: begin
        // entry at the cursor arrives while the partner is read
        mem_re    = 1'b1;
        mem_raddr = partner;
        tmp_d     = mem_rd_q;
        state_d   = fyse_pkg::ST_WRA;
      end
      fyse_pkg::ST_WRA: begin
        mem_we    = 1'b1;
        mem_waddr = cursor_q;
        mem_wdata = mem_rd_q;
        state_d   = fyse_pkg::ST_WRB;
      end
      fyse_pkg::ST_WRB: begin
        mem_we    = 1'b1;
        mem_waddr = partner;
        mem_wdata = tmp_q;
        cursor_d  = cursor_q + AW'(1);
        state_d   = fyse_pkg::ST_RES;
      end
      fyse_pkg::ST_RDX: begin
        res_val_d = fyse_pkg::RdValW'(mem_rd_q);
        state_d   = fyse_pkg::ST_RES;
      end
      fyse_pkg::ST_RES: begin
        // wait here while the previous word is still unclaimed
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = fyse_pkg::OutDataW'({res_st_q, no_step,
                                           fyse_pkg::PosW'(cursor_q), res_val_q});
          state_d   = fyse_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fyse_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= fyse_pkg::ST_IDLE;
      count_q   <= '0;
      cursor_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      cursor_q  <= cursor_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    span_q    <= span_d;
    rem_q     <= rem_d;
    dvd_q     <= dvd_d;
    bit_q     <= bit_d;
    tmp_q     <= tmp_d;
    res_val_q <= res_val_d;
    res_st_q  <= res_st_d;
    m_data_q  <= m_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rd_q <= mem_q[mem_raddr];
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(STORE_DEPTH))
    else $error("element count above store depth");

  a_cursor_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CW'(cursor_q) < count_q) || (count_q == '0 && cursor_q == '0))
    else $error("cursor outside filled store");

  a_rem_below_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fyse_pkg::ST_DIV) |-> (rem_q < span_q))
    else $error("partial remainder not below span");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == fyse_pkg::ST_IDLE || state_q == fyse_pkg::ST_WRA ||
                state_q == fyse_pkg::ST_WRB))
    else $error("store written outside load or swap");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready_o)
    else $error("word accepted while another is in work");

endmodule
